>>> rtl/core/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared sizes, codes and types for the port FIFO bank.
// ----------------------------------------------------------------------------
package pfb_pkg;

    localparam int PORT_COUNT   = 16;
    localparam int BUFFER_DEPTH = 128;
    localparam int ADDR_PORTS   = (PORT_COUNT < 16) ? PORT_COUNT : 16;

    localparam int PIDX_W  = $clog2(PORT_COUNT);
    localparam int PTR_W   = $clog2(BUFFER_DEPTH);
    localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
    localparam int BYTE_AW = PIDX_W + PTR_W;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_CLOSE   = 2'd1;
    localparam logic [1:0] OP_WRITE   = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOTOPEN = 3'd1;
    localparam logic [2:0] ST_UNAVAIL = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [7:0]       owner;
        logic [PTR_W-1:0] rd_ptr;
        logic [PTR_W-1:0] wr_ptr;
        logic [CNT_W-1:0] count;
    } desc_t;

    typedef struct packed {
        logic              en;
        logic [PIDX_W-1:0] addr;
        desc_t             data;
    } desc_wr_t;

    typedef struct packed {
        logic               en;
        logic [BYTE_AW-1:0] addr;
        logic [7:0]         data;
    } byte_wr_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] port;
        logic [7:0] data;
        logic [7:0] fill;
    } result_t;

endpackage

>>> rtl/core/pfb_desc_ram.sv
// ----------------------------------------------------------------------------
// pfb_desc_ram
// Per-port descriptor memory with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module pfb_desc_ram (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pfb_pkg::PIDX_W-1:0]  raddr,
    input  pfb_pkg::desc_wr_t           wr,
    output pfb_pkg::desc_t              rdata
);

    pfb_pkg::desc_t                    mem [pfb_pkg::PORT_COUNT];
    logic [pfb_pkg::PORT_COUNT-1:0]    vld_reg;
    pfb_pkg::desc_t                    rd_reg;
    logic                              rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[raddr];
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[raddr];
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

>>> rtl/core/pfb_byte_ram.sv
// ----------------------------------------------------------------------------
// pfb_byte_ram
// Byte store shared by all port ring buffers, with registered read.
// ----------------------------------------------------------------------------
module pfb_byte_ram (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [pfb_pkg::BYTE_AW-1:0]  raddr,
    input  pfb_pkg::byte_wr_t            wr,
    output logic [7:0]                   rdata
);

    logic [7:0] mem [2**pfb_pkg::BYTE_AW];
    logic [7:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= mem[raddr];
        end
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    assign rdata = rd_reg;

endmodule

>>> rtl/core/port_fifo_bank.sv
// ----------------------------------------------------------------------------
// port_fifo_bank
// Bank of per-port byte ring buffers with port acquire and close.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one command beat:
//   operation, port_index, pick_any, owner_id, data_in. The output channel
//   (out_valid/out_ready) returns one result beat per command: status,
//   port_out, data_out, fill_level. cfg_we/cfg_wdata write the reserved
//   port mask at once; write it only while the block is idle.
//   A command is taken in S_IDLE and its descriptor is read from the
//   descriptor memory; in S_EXEC it is modified and written back and the
//   result is registered for the output. A successful read also passes
//   through S_RDATA for the byte store read. A new command is taken only
//   back in S_IDLE, once the descriptor read-modify-write (and byte read)
//   of the last one is through.
//   If the receiver stalls, the result waits in the output register while
//   the next command is taken and processed; that one then waits in a
//   holding register until the output register frees up.
//   Reset empties and frees all ports and sets the mask to ports 0..2.
//   No clearing pass is needed.
// ----------------------------------------------------------------------------
module port_fifo_bank (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [3:0]  port_index,
    input  logic        pick_any,
    input  logic [7:0]  owner_id,
    input  logic [7:0]  data_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  port_out,
    output logic [7:0]  data_out,
    output logic [7:0]  fill_level
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RDATA = 2'd2;
    localparam logic [1:0] S_PUSH  = 2'd3;

    localparam int PIDX_W = pfb_pkg::PIDX_W;
    localparam int PTR_W  = pfb_pkg::PTR_W;
    localparam int CNT_W  = pfb_pkg::CNT_W;

    logic [1:0]                      state_reg, state_next;
    logic [15:0]                     mask_reg, mask_next;
    logic [pfb_pkg::PORT_COUNT-1:0]  open_reg, open_next;
    logic                            out_valid_reg, out_valid_next;

    logic [1:0]                      op_reg, op_next;
    logic [PIDX_W-1:0]               tgt_reg, tgt_next;
    logic                            any_reg, any_next;
    logic                            bad_reg, bad_next;
    logic                            nofree_reg, nofree_next;
    logic [7:0]                      owner_reg, owner_next;
    logic [7:0]                      din_reg, din_next;
    pfb_pkg::result_t                res_reg, res_next;
    pfb_pkg::result_t                out_reg, out_next;

    logic [pfb_pkg::PORT_COUNT-1:0]  rsv_vec;
    logic [pfb_pkg::PORT_COUNT-1:0]  free_vec;
    logic [PIDX_W-1:0]               lowest_free;
    logic                            accept;
    logic [PIDX_W-1:0]               desc_raddr;

    pfb_pkg::desc_t                  desc_rd;
    pfb_pkg::desc_t                  desc_upd;
    pfb_pkg::desc_wr_t               desc_wr;
    pfb_pkg::byte_wr_t               byte_wr;
    logic                            byte_rd_en;
    logic [pfb_pkg::BYTE_AW-1:0]     byte_raddr;
    logic [7:0]                      byte_rd;

    pfb_pkg::result_t                exe_res;
    pfb_pkg::result_t                fin;
    logic                            fin_valid;
    logic                            push_ok;
    logic                            rd_go;
    logic                            tgt_open;
    logic                            tgt_rsv;
    logic [PTR_W-1:0]                wr_ptr_inc;
    logic [PTR_W-1:0]                rd_ptr_inc;
    logic [CNT_W-1:0]                cnt_inc;
    logic [CNT_W-1:0]                cnt_dec;

    pfb_desc_ram u_desc_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (desc_raddr),
        .wr    (desc_wr),
        .rdata (desc_rd)
    );

    pfb_byte_ram u_byte_ram (
        .clk   (clk),
        .rd_en (byte_rd_en),
        .raddr (byte_raddr),
        .wr    (byte_wr),
        .rdata (byte_rd)
    );

    // free port search
    always_comb
    begin
        rsv_vec  = '0;
        free_vec = '0;
        for (int i = 0; i < pfb_pkg::ADDR_PORTS; i++)
        begin
            rsv_vec[i]  = mask_reg[i];
            free_vec[i] = !open_reg[i] && !mask_reg[i];
        end
        lowest_free = '0;
        for (int i = pfb_pkg::ADDR_PORTS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                lowest_free = PIDX_W'(i);
            end
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign push_ok  = !out_valid_reg || out_ready;

    assign desc_raddr = (operation == pfb_pkg::OP_ACQUIRE && pick_any)
                        ? lowest_free : PIDX_W'(port_index);

    assign tgt_rsv    = rsv_vec[tgt_reg];
    assign tgt_open   = open_reg[tgt_reg] || tgt_rsv;
    assign wr_ptr_inc = (desc_rd.wr_ptr == PTR_W'(pfb_pkg::BUFFER_DEPTH - 1))
                        ? '0 : desc_rd.wr_ptr + 1'b1;
    assign rd_ptr_inc = (desc_rd.rd_ptr == PTR_W'(pfb_pkg::BUFFER_DEPTH - 1))
                        ? '0 : desc_rd.rd_ptr + 1'b1;
    assign cnt_inc    = desc_rd.count + 1'b1;
    assign cnt_dec    = desc_rd.count - 1'b1;

    // execute: modify descriptor and build result
    always_comb
    begin
        open_next       = open_reg;
        desc_upd        = desc_rd;
        desc_wr.en      = 1'b0;
        desc_wr.addr    = tgt_reg;
        byte_wr.en      = 1'b0;
        byte_wr.addr    = {tgt_reg, desc_rd.wr_ptr};
        byte_wr.data    = din_reg;
        byte_rd_en      = 1'b0;
        byte_raddr      = {tgt_reg, desc_rd.rd_ptr};
        rd_go           = 1'b0;
        exe_res.status  = pfb_pkg::ST_OK;
        exe_res.port    = '0;
        exe_res.data    = '0;
        exe_res.fill    = 8'(desc_rd.count);

        if (state_reg == S_EXEC)
        begin
            if (op_reg == pfb_pkg::OP_ACQUIRE && any_reg)
            begin
                exe_res.fill = '0;
                if (nofree_reg)
                begin
                    exe_res.status = pfb_pkg::ST_UNAVAIL;
                end
                else
                begin
                    desc_upd          = '0;
                    desc_upd.owner    = owner_reg;
                    desc_wr.en        = 1'b1;
                    open_next[tgt_reg] = 1'b1;
                    exe_res.port      = 4'(tgt_reg);
                end
            end
            else if (bad_reg)
            begin
                exe_res.status = pfb_pkg::ST_NOTOPEN;
                exe_res.fill   = '0;
            end
            else
            begin
                unique case (op_reg)
                    pfb_pkg::OP_ACQUIRE:
                    begin
                        if (tgt_open)
                        begin
                            exe_res.status = pfb_pkg::ST_UNAVAIL;
                        end
                        else
                        begin
                            desc_upd           = '0;
                            desc_upd.owner     = owner_reg;
                            desc_wr.en         = 1'b1;
                            open_next[tgt_reg] = 1'b1;
                            exe_res.port       = 4'(tgt_reg);
                            exe_res.fill       = '0;
                        end
                    end
                    pfb_pkg::OP_CLOSE:
                    begin
                        if (tgt_rsv)
                        begin
                            exe_res.status = pfb_pkg::ST_UNAVAIL;
                        end
                        else if (!open_reg[tgt_reg])
                        begin
                            exe_res.status = pfb_pkg::ST_NOTOPEN;
                        end
                        else
                        begin
                            desc_upd           = '0;
                            desc_wr.en         = 1'b1;
                            open_next[tgt_reg] = 1'b0;
                            exe_res.fill       = '0;
                        end
                    end
                    pfb_pkg::OP_WRITE:
                    begin
                        if (!tgt_open)
                        begin
                            exe_res.status = pfb_pkg::ST_NOTOPEN;
                        end
                        else if (32'(desc_rd.count) >= 32'(pfb_pkg::BUFFER_DEPTH))
                        begin
                            exe_res.status = pfb_pkg::ST_FULL;
                        end
                        else
                        begin
                            byte_wr.en      = 1'b1;
                            desc_upd.wr_ptr = wr_ptr_inc;
                            desc_upd.count  = cnt_inc;
                            desc_wr.en      = 1'b1;
                            exe_res.fill    = 8'(cnt_inc);
                        end
                    end
                    pfb_pkg::OP_READ:
                    begin
                        if (!tgt_open)
                        begin
                            exe_res.status = pfb_pkg::ST_NOTOPEN;
                        end
                        else if (desc_rd.count == '0)
                        begin
                            exe_res.status = pfb_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            byte_rd_en      = 1'b1;
                            rd_go           = 1'b1;
                            desc_upd.rd_ptr = rd_ptr_inc;
                            desc_upd.count  = cnt_dec;
                            desc_wr.en      = 1'b1;
                            exe_res.fill    = 8'(cnt_dec);
                        end
                    end
                    default:
                    begin
                        exe_res.status = pfb_pkg::ST_NOTOPEN;
                    end
                endcase
            end
        end
        desc_wr.data = desc_upd;
    end

    // sequencing and output staging
    always_comb
    begin
        state_next     = state_reg;
        mask_next      = cfg_we ? cfg_wdata : mask_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        res_next       = res_reg;
        op_next        = op_reg;
        tgt_next       = tgt_reg;
        any_next       = any_reg;
        bad_next       = bad_reg;
        nofree_next    = nofree_reg;
        owner_next     = owner_reg;
        din_next       = din_reg;
        fin            = res_reg;
        fin_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = operation;
                    tgt_next    = desc_raddr;
                    any_next    = pick_any;
                    bad_next    = !(operation == pfb_pkg::OP_ACQUIRE && pick_any)
                                  && (32'(port_index) >= 32'(pfb_pkg::PORT_COUNT));
                    nofree_next = !(|free_vec);
                    owner_next  = owner_id;
                    din_next    = data_in;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (rd_go)
                begin
                    res_next   = exe_res;
                    state_next = S_RDATA;
                end
                else
                begin
                    fin       = exe_res;
                    fin_valid = 1'b1;
                end
            end
            S_RDATA:
            begin
                fin       = res_reg;
                fin.data  = byte_rd;
                fin_valid = 1'b1;
            end
            S_PUSH:
            begin
                fin_valid = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin_valid)
        begin
            if (push_ok)
            begin
                out_next       = fin;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = fin;
                state_next = S_PUSH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mask_reg      <= 16'd7;
            open_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        tgt_reg    <= tgt_next;
        any_reg    <= any_next;
        bad_reg    <= bad_next;
        nofree_reg <= nofree_next;
        owner_reg  <= owner_next;
        din_reg    <= din_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign port_out   = out_reg.port;
    assign data_out   = out_reg.data;
    assign fill_level = out_reg.fill;

endmodule
